>>> hdl/cta_pkg.sv
// Shared types, constants and month-length lookup for the timezone adjust unit.
package cta_pkg;

	localparam int SecW   = 6;
	localparam int MinW   = 6;
	localparam int HourW  = 5;
	localparam int DayW   = 5;
	localparam int MonW   = 4;
	localparam int YearW  = 7;
	localparam int OffW   = 6;

	localparam logic [HourW-1:0]        HourMax     = 5'd23;
	localparam logic signed [HourW+1:0] HoursPerDay = 7'sd24;
	localparam logic [MonW-1:0]         MonFirst    = 4'd1;
	localparam logic [MonW-1:0]         MonFeb      = 4'd2;
	localparam logic [MonW-1:0]         MonLast     = 4'd12;
	localparam logic [DayW-1:0]         DayFirst    = 5'd1;
	localparam logic [DayW-1:0]         DaysLeapFeb = 5'd29;
	localparam logic [YearW-1:0]        YearFirst   = 7'd0;
	localparam logic [YearW-1:0]        YearLast    = 7'd99;
	localparam logic signed [OffW-1:0]  OffsetMax   = 6'sd23;
	localparam logic signed [OffW-1:0]  OffsetMin   = -6'sd23;

	localparam logic [DayW-1:0] MonthLen [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Sanitised request held between the input and result registers
	typedef struct packed {
		logic [SecW-1:0]        sec;
		logic [MinW-1:0]        min;
		logic [HourW-1:0]       hour;
		logic [DayW-1:0]        day;
		logic [MonW-1:0]        mon;
		logic [YearW-1:0]       year;
		logic signed [OffW-1:0] offset;
	} cta_item_t;

	typedef struct packed {
		logic [SecW-1:0]  sec;
		logic [MinW-1:0]  min;
		logic [HourW-1:0] hour;
		logic [DayW-1:0]  day;
		logic [MonW-1:0]  mon;
		logic [YearW-1:0] year;
	} cta_result_t;

	// Years 2000..2099: divisible by four is leap (2000 is a 400 year)
	function automatic logic [DayW-1:0] days_of(input logic [MonW-1:0] mon,
			input logic [YearW-1:0] year);
		if (mon == MonFeb && year[1:0] == 2'b00) begin
			return DaysLeapFeb;
		end
		return MonthLen[mon];
	endfunction

endpackage

>>> hdl/calendar_timezone_adjust_unit.sv
// Top level of the calendar timezone adjust unit: offset register and two-stage datapath.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------------
//  request   start / busy           utc_seconds, utc_minutes, utc_hours, utc_day,
//                                   utc_month, utc_year
//  result    done (one-cycle)       local_seconds, local_minutes, local_hours,
//                                   local_day, local_month, local_year
//  config    cfg_valid / cfg_ready  cfg_data (signed hour offset)
//
// One request per cycle; busy never rises.
// A request passes through the input register, then the hour add and date roll into the result register.
// done is high for one cycle per request; the receiver cannot stall it.
// arst_n clears the offset to zero and empties both stages.
module calendar_timezone_adjust_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [cta_pkg::SecW-1:0]        utc_seconds,
	input  logic [cta_pkg::MinW-1:0]        utc_minutes,
	input  logic [cta_pkg::HourW-1:0]       utc_hours,
	input  logic [cta_pkg::DayW-1:0]        utc_day,
	input  logic [cta_pkg::MonW-1:0]        utc_month,
	input  logic [cta_pkg::YearW-1:0]       utc_year,
	output logic                            done,
	output logic [cta_pkg::SecW-1:0]        local_seconds,
	output logic [cta_pkg::MinW-1:0]        local_minutes,
	output logic [cta_pkg::HourW-1:0]       local_hours,
	output logic [cta_pkg::DayW-1:0]        local_day,
	output logic [cta_pkg::MonW-1:0]        local_month,
	output logic [cta_pkg::YearW-1:0]       local_year,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic signed [cta_pkg::OffW-1:0] cfg_data
);
	import cta_pkg::*;

	logic signed [OffW-1:0] offset_q;
	logic                   take;
	cta_item_t              item_s1;
	logic                   valid_s1;
	cta_result_t            result_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	cta_sanitise u_sanitise (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.utc_seconds (utc_seconds),
		.utc_minutes (utc_minutes),
		.utc_hours   (utc_hours),
		.utc_day     (utc_day),
		.utc_month   (utc_month),
		.utc_year    (utc_year),
		.offset      (offset_q),
		.item_s1     (item_s1),
		.valid_s1    (valid_s1)
	);

	cta_roll u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.valid_s1  (valid_s1),
		.result_s2 (result_s2),
		.valid_s2  (done)
	);

	assign local_seconds = result_s2.sec;
	assign local_minutes = result_s2.min;
	assign local_hours   = result_s2.hour;
	assign local_day     = result_s2.day;
	assign local_month   = result_s2.mon;
	assign local_year    = result_s2.year;

	// Every request yields exactly one result after the input and result registers
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##2 done)
		else $error("request did not produce a result");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 2))
		else $error("result without a request");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (local_hours <= HourMax) && (local_day >= DayFirst)
			&& (local_month >= MonFirst) && (local_month <= MonLast)
			&& (local_year <= YearLast))
		else $error("result field out of range");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (local_seconds == $past(utc_seconds, 2))
			&& (local_minutes == $past(utc_minutes, 2)))
		else $error("seconds or minutes altered");

endmodule

>>> hdl/cta_sanitise.sv
// Input register stage: clamps hour, month, year and offset into their legal ranges and raises day zero to one.
module cta_sanitise (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic [cta_pkg::SecW-1:0]             utc_seconds,
	input  logic [cta_pkg::MinW-1:0]             utc_minutes,
	input  logic [cta_pkg::HourW-1:0]            utc_hours,
	input  logic [cta_pkg::DayW-1:0]             utc_day,
	input  logic [cta_pkg::MonW-1:0]             utc_month,
	input  logic [cta_pkg::YearW-1:0]            utc_year,
	input  logic signed [cta_pkg::OffW-1:0]      offset,
	output cta_pkg::cta_item_t                   item_s1,
	output logic                                 valid_s1
);
	import cta_pkg::*;

	cta_item_t item_d;

	always_comb begin
		item_d.sec  = utc_seconds;
		item_d.min  = utc_minutes;
		item_d.hour = (utc_hours > HourMax) ? HourMax : utc_hours;
		item_d.day  = (utc_day < DayFirst) ? DayFirst : utc_day;
		if (utc_month < MonFirst) begin
			item_d.mon = MonFirst;
		end else if (utc_month > MonLast) begin
			item_d.mon = MonLast;
		end else begin
			item_d.mon = utc_month;
		end
		item_d.year = (utc_year > YearLast) ? YearLast : utc_year;
		if (offset < OffsetMin) begin
			item_d.offset = OffsetMin;
		end else if (offset > OffsetMax) begin
			item_d.offset = OffsetMax;
		end else begin
			item_d.offset = offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> hdl/cta_roll.sv
// Result register stage: adds the offset to the hour and rolls day, month and year.
module cta_roll (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cta_pkg::cta_item_t   item_s1,
	input  logic                 valid_s1,
	output cta_pkg::cta_result_t result_s2,
	output logic                 valid_s2
);
	import cta_pkg::*;

	logic signed [HourW+1:0] hour_sum;
	logic signed [HourW+1:0] hour_fwd;
	logic signed [HourW+1:0] hour_bwd;
	logic [MonW-1:0]         mon_prev;
	logic [YearW-1:0]        year_prev;
	cta_result_t             res_d;

	assign hour_sum = $signed({2'b00, item_s1.hour})
		+ $signed({item_s1.offset[OffW-1], item_s1.offset});
	assign hour_fwd = hour_sum - HoursPerDay;
	assign hour_bwd = hour_sum + HoursPerDay;

	// Previous month and year for a backward roll off day one
	always_comb begin
		if (item_s1.mon <= MonFirst) begin
			mon_prev  = MonLast;
			year_prev = (item_s1.year == YearFirst) ? YearLast : item_s1.year - 7'd1;
		end else begin
			mon_prev  = item_s1.mon - 4'd1;
			year_prev = item_s1.year;
		end
	end

	always_comb begin
		res_d.sec  = item_s1.sec;
		res_d.min  = item_s1.min;
		res_d.hour = item_s1.hour;
		res_d.day  = item_s1.day;
		res_d.mon  = item_s1.mon;
		res_d.year = item_s1.year;
		if (hour_sum >= HoursPerDay) begin
			res_d.hour = hour_fwd[HourW-1:0];
			if (item_s1.day >= days_of(item_s1.mon, item_s1.year)) begin
				res_d.day = DayFirst;
				if (item_s1.mon >= MonLast) begin
					res_d.mon  = MonFirst;
					res_d.year = (item_s1.year >= YearLast) ? YearFirst
						: item_s1.year + 7'd1;
				end else begin
					res_d.mon = item_s1.mon + 4'd1;
				end
			end else begin
				res_d.day = item_s1.day + 5'd1;
			end
		end else if (hour_sum < 7'sd0) begin
			res_d.hour = hour_bwd[HourW-1:0];
			if (item_s1.day <= DayFirst) begin
				res_d.mon  = mon_prev;
				res_d.year = year_prev;
				res_d.day  = days_of(mon_prev, year_prev);
			end else begin
				res_d.day = item_s1.day - 5'd1;
			end
		end else begin
			res_d.hour = hour_sum[HourW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= res_d;
		end
	end

endmodule

>>> verif/tb_calendar_timezone_adjust_unit.sv
// Self-checking testbench for calendar_timezone_adjust_unit: random bursts, offset phases, date rolls.
module tb_calendar_timezone_adjust_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cta_pkg::*;

	localparam int StallLimit = 500;
	localparam int DrainCycles = 4;
	localparam int MonthDays [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef enum logic [1:0] {
		REQ_CONVERT,
		REQ_SET_OFFSET,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t              kind;
		logic [SecW-1:0]        sec;
		logic [MinW-1:0]        min;
		logic [HourW-1:0]       hour;
		logic [DayW-1:0]        day;
		logic [MonW-1:0]        mon;
		logic [YearW-1:0]       year;
		logic signed [OffW-1:0] offset;
	} utc_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [SecW-1:0]        utc_seconds = '0;
	logic [MinW-1:0]        utc_minutes = '0;
	logic [HourW-1:0]       utc_hours = '0;
	logic [DayW-1:0]        utc_day = '0;
	logic [MonW-1:0]        utc_month = '0;
	logic [YearW-1:0]       utc_year = '0;
	logic                   done;
	logic [SecW-1:0]        local_seconds;
	logic [MinW-1:0]        local_minutes;
	logic [HourW-1:0]       local_hours;
	logic [DayW-1:0]        local_day;
	logic [MonW-1:0]        local_month;
	logic [YearW-1:0]       local_year;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic signed [OffW-1:0] cfg_data = '0;

	utc_req_t               pending_reqs [$];
	cta_result_t            expected_local [$];
	logic signed [OffW-1:0] tz_offset = '0;
	int                     planned_converts = 0;
	int                     planned_offsets = 0;
	int                     convert_count = 0;
	int                     local_count = 0;
	int                     offset_writes = 0;
	int                     mismatches = 0;
	int                     idle_cycles = 0;
	logic                   req_taken = 1'b0;
	logic                   cfg_taken = 1'b0;

	calendar_timezone_adjust_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.utc_seconds   (utc_seconds),
		.utc_minutes   (utc_minutes),
		.utc_hours     (utc_hours),
		.utc_day       (utc_day),
		.utc_month     (utc_month),
		.utc_year      (utc_year),
		.done          (done),
		.local_seconds (local_seconds),
		.local_minutes (local_minutes),
		.local_hours   (local_hours),
		.local_day     (local_day),
		.local_month   (local_month),
		.local_year    (local_year),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int month_days(input int mon, input int yr);
		int full;
		full = 2000 + yr;
		if (mon == 2 && (((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0))) begin
			return 29;
		end
		return MonthDays[mon];
	endfunction

	function automatic cta_result_t shift_to_local(input logic [SecW-1:0] s,
			input logic [MinW-1:0] mi, input logic [HourW-1:0] h, input logic [DayW-1:0] d,
			input logic [MonW-1:0] mo, input logic [YearW-1:0] y,
			input logic signed [OffW-1:0] offs);
		int          off;
		int          hr;
		int          day;
		int          mon;
		int          yr;
		cta_result_t res;
		off = offs;
		hr = h;
		day = d;
		mon = mo;
		yr = y;
		// out-of-range fields are clamped before the shift
		if (off > 23) off = 23;
		if (off < -23) off = -23;
		if (hr > 23) hr = 23;
		if (mon < 1) mon = 1;
		if (mon > 12) mon = 12;
		if (day < 1) day = 1;
		if (yr > 99) yr = 99;
		hr += off;
		if (hr >= 24) begin
			hr -= 24;
			if (day >= month_days(mon, yr)) begin
				day = 1;
				if (mon == 12) begin
					mon = 1;
					yr = (yr == 99) ? 0 : yr + 1;
				end else begin
					mon++;
				end
			end else begin
				day++;
			end
		end else if (hr < 0) begin
			hr += 24;
			if (day == 1) begin
				if (mon == 1) begin
					mon = 12;
					yr = (yr == 0) ? 99 : yr - 1;
				end else begin
					mon--;
				end
				day = month_days(mon, yr);
			end else begin
				// day 31 of a short month just steps back, e.g. 31 Feb to 30 Feb
				day--;
			end
		end
		res.sec = s;
		res.min = mi;
		res.hour = hr[HourW-1:0];
		res.day = day[DayW-1:0];
		res.mon = mon[MonW-1:0];
		res.year = yr[YearW-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_local(input cta_result_t got, input cta_result_t want);
		if (got.sec != want.sec) report_mismatch("local_seconds", got.sec, want.sec);
		if (got.min != want.min) report_mismatch("local_minutes", got.min, want.min);
		if (got.hour != want.hour) report_mismatch("local_hours", got.hour, want.hour);
		if (got.day != want.day) report_mismatch("local_day", got.day, want.day);
		if (got.mon != want.mon) report_mismatch("local_month", got.mon, want.mon);
		if (got.year != want.year) report_mismatch("local_year", got.year, want.year);
	endtask

	function automatic void add_convert(input int s, input int mi, input int h, input int d,
			input int mo, input int y);
		utc_req_t r;
		r.kind = REQ_CONVERT;
		r.sec = s[SecW-1:0];
		r.min = mi[MinW-1:0];
		r.hour = h[HourW-1:0];
		r.day = d[DayW-1:0];
		r.mon = mo[MonW-1:0];
		r.year = y[YearW-1:0];
		r.offset = '0;
		pending_reqs.push_back(r);
		planned_converts++;
	endfunction

	function automatic void add_offset(input int v);
		utc_req_t r;
		r = '{REQ_SET_OFFSET, '0, '0, '0, '0, '0, '0, v[OffW-1:0]};
		pending_reqs.push_back(r);
		planned_offsets++;
	endfunction

	function automatic void add_drain();
		utc_req_t r;
		r = '{REQ_DRAIN, '0, '0, '0, '0, '0, '0, '0};
		pending_reqs.push_back(r);
	endfunction

	// Driver: pops requests, bursts with random gaps, offset writes only once idle
	utc_req_t cur;
	logic     have_cur = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(negedge clk) begin
		logic drive_start;
		logic drive_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if ((start && req_taken) || (cfg_valid && cfg_taken)) have_cur = 1'b0;
			if (have_cur && cur.kind == REQ_DRAIN && expected_local.size() == 0) have_cur = 1'b0;
			if (!have_cur && gap_left > 0) begin
				gap_left--;
			end else if (!have_cur && pending_reqs.size() > 0) begin
				cur = pending_reqs.pop_front();
				have_cur = 1'b1;
				if (cur.kind == REQ_CONVERT) begin
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			drive_start = have_cur && cur.kind == REQ_CONVERT;
			drive_cfg = have_cur && cur.kind == REQ_SET_OFFSET && expected_local.size() == 0;
			start <= drive_start;
			cfg_valid <= drive_cfg;
			if (have_cur) begin
				utc_seconds <= cur.sec;
				utc_minutes <= cur.min;
				utc_hours <= cur.hour;
				utc_day <= cur.day;
				utc_month <= cur.mon;
				utc_year <= cur.year;
				cfg_data <= cur.offset;
			end
		end
	end

	// Monitor: checks results, predicts on each accepted request, tracks offset writes
	always @(posedge clk) begin
		cta_result_t got;
		cta_result_t want;
		if (arst_n) begin
			if (done) begin
				got = {local_seconds, local_minutes, local_hours, local_day, local_month,
					local_year};
				local_count++;
				if (expected_local.size() == 0) begin
					report_mismatch("result with nothing outstanding", got.hour, -1);
				end else begin
					want = expected_local.pop_front();
					check_local(got, want);
				end
			end
			if (start && !busy) begin
				expected_local.push_back(shift_to_local(utc_seconds, utc_minutes, utc_hours,
					utc_day, utc_month, utc_year, tz_offset));
				convert_count++;
			end
			if (cfg_valid && cfg_ready) begin
				tz_offset = cfg_data;
				offset_writes++;
			end
			idle_cycles <= (done || (start && !busy) || (cfg_valid && cfg_ready)) ? 0
				: idle_cycles + 1;
		end
		req_taken <= arst_n && start && !busy;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
	end

	initial begin
		int off;
		int yr;
		int mo;
		int dl;
		int dy;
		int hr;

		// reset offset of zero, then field extremes and clamping
		add_convert(0, 0, 0, 1, 1, 0);
		add_convert(63, 63, 31, 31, 15, 127);
		add_convert(0, 0, 0, 0, 0, 0);
		// forward rolls
		add_offset(23);
		add_convert(59, 59, 23, 31, 12, 99);
		add_convert(1, 2, 1, 28, 2, 24);
		add_convert(1, 2, 5, 28, 2, 23);
		add_convert(3, 4, 5, 29, 2, 0);
		add_convert(5, 6, 10, 31, 4, 50);
		add_convert(7, 8, 0, 15, 6, 10);
		add_convert(0, 0, 20, 0, 15, 127);
		// backward rolls
		add_offset(-23);
		add_convert(0, 0, 0, 1, 1, 0);
		add_convert(0, 0, 10, 1, 3, 24);
		add_convert(0, 0, 10, 1, 3, 23);
		add_convert(0, 0, 5, 31, 2, 23);
		add_convert(0, 0, 22, 0, 0, 0);
		add_convert(0, 0, 23, 10, 10, 10);
		add_convert(0, 0, 31, 10, 10, 10);
		// offsets beyond +-23 saturate
		add_offset(31);
		add_convert(0, 0, 12, 30, 6, 5);
		add_offset(-32);
		add_convert(0, 0, 0, 1, 5, 5);
		add_offset(24);
		add_convert(0, 0, 1, 15, 8, 40);
		add_offset(-24);
		add_convert(0, 0, 22, 15, 8, 40);

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: off = 23;
				1: off = -23;
				2: off = 31;
				3: off = -32;
				4: off = 0;
				default: off = $urandom_range(0, 63);
			endcase
			add_offset(off);
			for (int n = 0; n < 70; n++) begin
				if ((ph == 5 && n == 35) || $urandom_range(0, 199) == 0) add_drain();
				if ($urandom_range(0, 99) < 85) begin
					yr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 99 : 0)
						: $urandom_range(0, 99);
					mo = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12 : 1)
						: $urandom_range(1, 12);
					dl = month_days(mo, yr);
					case ($urandom_range(0, 3))
						0: dy = 1;
						1: dy = dl;
						2: dy = dl - 1;
						default: dy = $urandom_range(1, dl);
					endcase
					case ($urandom_range(0, 3))
						0: hr = $urandom_range(0, 2);
						1: hr = $urandom_range(21, 23);
						default: hr = $urandom_range(0, 23);
					endcase
					add_convert($urandom_range(0, 59), $urandom_range(0, 59), hr, dy, mo, yr);
				end else begin
					add_convert($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
						$urandom_range(0, 127));
				end
			end
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (!(convert_count == planned_converts && offset_writes == planned_offsets
				&& expected_local.size() == 0) && idle_cycles < StallLimit) begin
			@(negedge clk);
		end
		if (idle_cycles >= StallLimit) begin
			$display("watchdog: nothing accepted for %0d cycles", StallLimit);
			mismatches++;
		end else begin
			repeat (DrainCycles) @(negedge clk);
		end

		$display("covered %0d conversions and %0d results over %0d offset writes", convert_count,
			local_count, offset_writes);
		$display("offsets included +-23 and saturating values; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
